>>> rtl/core/dfe_pkg.sv
`timescale 1ns / 1ps
package dfe_pkg;

  localparam int FRAME_BITS = 16;
  localparam int CNT_W      = $clog2(FRAME_BITS);
  localparam int VALUE_W    = 11;
  localparam int CRC_W      = 4;
  localparam int TICK_W     = 7;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  localparam logic [VALUE_W-1:0] CMD_MAX      = VALUE_W'(47);
  localparam logic [VALUE_W-1:0] THROTTLE_MIN = VALUE_W'(48);

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIDIRECTIONAL = 1'b1;

  localparam logic OP_THROTTLE = 1'b0;
  localparam logic OP_COMMAND  = 1'b1;

  localparam logic [MODE_W-1:0] SPEED_OFF  = 3'd0;
  localparam logic [MODE_W-1:0] SPEED_150  = 3'd1;
  localparam logic [MODE_W-1:0] SPEED_300  = 3'd2;
  localparam logic [MODE_W-1:0] SPEED_600  = 3'd3;
  localparam logic [MODE_W-1:0] SPEED_1200 = 3'd4;

  typedef struct packed {
    logic                  reject;
    logic [FRAME_BITS-1:0] frame;
  } dfe_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dfe_q_stat_t;

  typedef struct packed {
    logic [TICK_W-1:0] high;
    logic [TICK_W-1:0] low;
  } tick_pair_t;

  function automatic tick_pair_t symbol_ticks(input logic [MODE_W-1:0] mode, input logic bit_val);
    tick_pair_t t;
    t = '0;
    unique case (mode)
      SPEED_150:  t = bit_val ? {7'd48, 7'd16} : {7'd24, 7'd40};
      SPEED_300:  t = bit_val ? {7'd24, 7'd8}  : {7'd12, 7'd20};
      SPEED_600:  t = bit_val ? {7'd12, 7'd4}  : {7'd6,  7'd10};
      SPEED_1200: t = bit_val ? {7'd6,  7'd2}  : {7'd3,  7'd5};
      default:    t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [FRAME_BITS-1:0] build_frame(input logic [VALUE_W-1:0] value,
                                                        input logic bidir);
    logic [VALUE_W:0]  data;
    logic [CRC_W-1:0]  crc;
    data = {value, bidir};
    crc  = data[3:0] ^ data[7:4] ^ data[11:8];
    if (bidir) begin
      crc = ~crc;
    end
    return {data, crc};
  endfunction

endpackage

>>> rtl/core/dfe_in_if.sv
`timescale 1ns / 1ps
interface dfe_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [dfe_pkg::VALUE_W-1:0]  request_value;

  modport source (output valid, output operation, output request_value, input ready);
  modport sink   (input valid, input operation, input request_value, output ready);
endinterface

>>> rtl/core/dfe_out_if.sv
`timescale 1ns / 1ps
interface dfe_out_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic                        first_level;
  logic [dfe_pkg::TICK_W-1:0]  first_ticks;
  logic                        second_level;
  logic [dfe_pkg::TICK_W-1:0]  second_ticks;
  logic                        frame_bit;
  logic                        last;

  modport source (output valid, output status, output first_level, output first_ticks,
                  output second_level, output second_ticks, output frame_bit,
                  output last, input ready);
  modport sink   (input valid, input status, input first_level, input first_ticks,
                  input second_level, input second_ticks, input frame_bit,
                  input last, output ready);
endinterface

>>> rtl/core/dfe_front.sv
`timescale 1ns / 1ps
module dfe_front (
  dfe_in_if.sink                 in,
  input  logic                   bidirectional,
  input  dfe_pkg::dfe_q_stat_t   q_stat,
  output logic                   push,
  output dfe_pkg::dfe_entry_t    push_entry
);

  logic [dfe_pkg::VALUE_W-1:0] value;
  logic                        reject;

  always_comb begin
    value  = in.request_value;
    reject = 1'b0;
    unique case (in.operation)
      dfe_pkg::OP_THROTTLE: begin
        if (in.request_value != '0 && in.request_value < dfe_pkg::THROTTLE_MIN) begin
          value = dfe_pkg::THROTTLE_MIN;
        end
      end
      dfe_pkg::OP_COMMAND: begin
        reject = in.request_value > dfe_pkg::CMD_MAX;
      end
      default: value = in.request_value;
    endcase
  end

  assign in.ready         = !q_stat.full;
  assign push             = in.valid && !q_stat.full;
  assign push_entry.reject = reject;
  assign push_entry.frame  = dfe_pkg::build_frame(value, bidirectional);

endmodule

>>> rtl/core/dfe_queue.sv
`timescale 1ns / 1ps
module dfe_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  dfe_pkg::dfe_entry_t   push_entry,
  input  logic                  pop,
  output dfe_pkg::dfe_entry_t   pop_entry,
  output dfe_pkg::dfe_q_stat_t  q_stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int LVL_W = $clog2(DEPTH + 1);

  dfe_pkg::dfe_entry_t slots [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [LVL_W-1:0]    level;
  logic                do_push;
  logic                do_pop;

  assign q_stat.full  = level == LVL_W'(DEPTH);
  assign q_stat.empty = level == '0;
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_entry    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        level <= level + 1'b1;
      end else if (do_pop && !do_push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/dfe_back.sv
`timescale 1ns / 1ps
module dfe_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [dfe_pkg::MODE_W-1:0]    speed_mode,
  input  logic                          bidirectional,
  input  dfe_pkg::dfe_q_stat_t          q_stat,
  input  dfe_pkg::dfe_entry_t           pop_entry,
  output logic                          pop,
  dfe_out_if.source                     out
);

  localparam logic [dfe_pkg::CNT_W-1:0] LAST_IDX = dfe_pkg::CNT_W'(dfe_pkg::FRAME_BITS - 1);

  logic                              active;
  logic                              reject;
  logic [dfe_pkg::FRAME_BITS-1:0]    frame_shift;
  logic [dfe_pkg::CNT_W-1:0]         bit_count;
  logic                              out_valid;
  logic                              can_emit;
  logic                              emit_last;
  logic                              cur_bit;
  dfe_pkg::tick_pair_t               ticks;

  logic                              o_status;
  logic                              o_first_level;
  logic [dfe_pkg::TICK_W-1:0]        o_first_ticks;
  logic                              o_second_level;
  logic [dfe_pkg::TICK_W-1:0]        o_second_ticks;
  logic                              o_frame_bit;
  logic                              o_last;

  assign cur_bit   = frame_shift[dfe_pkg::FRAME_BITS-1];
  assign ticks     = dfe_pkg::symbol_ticks(speed_mode, cur_bit);
  assign can_emit  = active && (!out_valid || out.ready);
  assign emit_last = can_emit && (reject || bit_count == LAST_IDX);
  assign pop       = !q_stat.empty && (!active || emit_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (can_emit) begin
        out_valid <= 1'b1;
      end else if (out.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        active <= 1'b1;
      end else if (emit_last) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      reject      <= pop_entry.reject;
      frame_shift <= pop_entry.frame;
      bit_count   <= '0;
    end else if (can_emit) begin
      frame_shift <= frame_shift << 1;
      bit_count   <= bit_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (can_emit) begin
      if (reject) begin
        o_status       <= 1'b1;
        o_first_level  <= 1'b0;
        o_first_ticks  <= '0;
        o_second_level <= 1'b0;
        o_second_ticks <= '0;
        o_frame_bit    <= 1'b0;
        o_last         <= 1'b1;
      end else begin
        o_status       <= 1'b0;
        o_first_level  <= !bidirectional;
        o_first_ticks  <= ticks.high;
        o_second_level <= bidirectional;
        o_second_ticks <= ticks.low;
        o_frame_bit    <= cur_bit;
        o_last         <= bit_count == LAST_IDX;
      end
    end
  end

  assign out.valid        = out_valid;
  assign out.status       = o_status;
  assign out.first_level  = o_first_level;
  assign out.first_ticks  = o_first_ticks;
  assign out.second_level = o_second_level;
  assign out.second_ticks = o_second_ticks;
  assign out.frame_bit    = o_frame_bit;
  assign out.last         = o_last;

endmodule

>>> rtl/core/dshot_frame_encoder_core.sv
`timescale 1ns / 1ps
// DShot frame encoder core.
// in:  request transactions (operation, request_value), valid/ready.
// out: symbol transactions (status, levels, tick counts, frame_bit, last).
// cfg: write port; index 0 speed_mode, index 1 bidirectional. Write only
//      while no request is in flight.
// A throttle or in-range command yields 16 symbols, MSB first, last set on
// the final one. A command above 47 yields one rejection with last set.
// A request passes through the queue, the symbol sequencer and the output
// register. One symbol per cycle while the receiver is ready; the request
// queue lets the next request be taken while the current frame is still
// being sent.
// Reset clears the queue, the symbol sequencer, the output valid and both
// configuration registers (speed off, unidirectional).
// When the receiver stalls, the output symbol holds, the sequencer waits,
// and requests keep being accepted until the queue is full.
module dshot_frame_encoder_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dfe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dfe_pkg::CFG_DATA_W-1:0]   cfg_data,
  dfe_in_if.sink                           in,
  dfe_out_if.source                        out
);

  logic [dfe_pkg::MODE_W-1:0] speed_mode;
  logic                       bidirectional;
  logic                       push;
  logic                       pop;
  dfe_pkg::dfe_entry_t        push_entry;
  dfe_pkg::dfe_entry_t        pop_entry;
  dfe_pkg::dfe_q_stat_t       q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_mode    <= dfe_pkg::SPEED_OFF;
      bidirectional <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dfe_pkg::CFG_SPEED_MODE:    speed_mode    <= cfg_data[dfe_pkg::MODE_W-1:0];
        dfe_pkg::CFG_BIDIRECTIONAL: bidirectional <= cfg_data[0];
        default:                    speed_mode    <= speed_mode;
      endcase
    end
  end

  dfe_front u_front (
    .in            (in),
    .bidirectional (bidirectional),
    .q_stat        (q_stat),
    .push          (push),
    .push_entry    (push_entry)
  );

  dfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_stat     (q_stat)
  );

  dfe_back u_back (
    .clk           (clk),
    .rst           (rst),
    .speed_mode    (speed_mode),
    .bidirectional (bidirectional),
    .q_stat        (q_stat),
    .pop_entry     (pop_entry),
    .pop           (pop),
    .out           (out)
  );

  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !out.valid)
    else $error("output valid right after reset");

  a_q_consistent: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in.valid && in.ready |=> !q_stat.empty || out.valid)
    else $error("accepted transaction vanished");

  a_reject_shape: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.status |-> out.last && out.first_ticks == '0 && out.second_ticks == '0)
    else $error("rejection transaction malformed");

endmodule
